[sv/wmom_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the windowed mean overheat monitor.
// No dependencies; every other file of the block refers to it by scoped names.
package wmom_pkg;

  // Fixed field widths
  localparam int WLEN_W     = 5;
  localparam int THR_W      = 16;
  localparam int STAMP_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WINDOW_LENGTH      = 2'd0;
  localparam cfg_idx_t CFG_OVERHEAT_THRESHOLD = 2'd1;

  // Register reset values (threshold is 60.0 C in Q8.8)
  localparam logic [WLEN_W-1:0]       WLEN_RESET = 5'd10;
  localparam logic signed [THR_W-1:0] THR_RESET  = 16'sd15360;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE
  } state_t;

  // Window store controls
  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } win_ctl_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

[sv/wmom_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample items, mean results, register writes.
// Depends on wmom_pkg for the fixed field widths.
interface wmom_item_if #(parameter int SAMPLE_BITS = 16);
  logic                                 valid;
  logic                                 ready;
  logic signed [SAMPLE_BITS-1:0]        sample;
  logic signed [wmom_pkg::STAMP_W-1:0]  stamp_seconds;
  logic [wmom_pkg::STAMP_W-1:0]         stamp_nanoseconds;

  modport source (output valid, output sample, output stamp_seconds,
                  output stamp_nanoseconds, input ready);
  modport sink   (input valid, input sample, input stamp_seconds,
                  input stamp_nanoseconds, output ready);
endinterface

interface wmom_result_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic                          overheat;

  modport source (output valid, output mean, output overheat, input ready);
  modport sink   (input valid, input mean, input overheat, output ready);
endinterface

interface wmom_cfg_if;
  logic                              valid;
  logic                              ready;
  wmom_pkg::cfg_idx_t                idx;
  logic [wmom_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

[sv/wmom_window.sv]
`timescale 1ns / 1ps
// Sample window: circular sample memory, write slot, fill count and running sum.
// Depends on wmom_pkg for the control struct.
module wmom_window #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16,
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1),
  localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wmom_pkg::win_ctl_t            ctl,
  input  logic [CNT_W-1:0]              len,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SUM_W-1:0]       sum,
  output logic [CNT_W-1:0]              count
);

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [SLOT_W-1:0]             write_slot;
  logic [SLOT_W-1:0]             write_slot_next;
  logic [SLOT_W-1:0]             slot_q;
  logic [SLOT_W-1:0]             slot_start;
  logic [CNT_W-1:0]              slot_inc;
  logic [CNT_W-1:0]              count_next;
  logic                          full;
  logic signed [SUM_W-1:0]       drop;
  logic signed [SUM_W-1:0]       sum_next;

  // Wrap the slot when the window was shortened below it
  assign slot_start = (CNT_W'(write_slot) >= len) ? '0 : write_slot;

  // Drop the oldest sample once the window is full
  assign full       = (count >= len);
  assign drop       = full ? SUM_W'(rd_data) : '0;
  assign sum_next   = sum - drop + SUM_W'(sample_q);
  assign count_next = full ? len : count + 1'b1;

  // Advance the write slot around the window
  assign slot_inc        = CNT_W'(slot_q) + 1'b1;
  assign write_slot_next = (slot_inc >= len) ? '0 : SLOT_W'(slot_inc);

  // Window control state
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      write_slot <= '0;
      count      <= '0;
      sum        <= '0;
    end else if (ctl.commit) begin
      write_slot <= write_slot_next;
      count      <= count_next;
      sum        <= sum_next;
    end
  end

  // Hold the accepted sample and its slot
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_q <= sample;
      slot_q   <= slot_start;
    end
  end

  // Sample memory: registered read of the slot, write on commit
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      mem[slot_q] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[slot_q];
  end

endmodule

[sv/wmom_smul.sv]
`timescale 1ns / 1ps
// Serial shift-add multiplier: threshold times fill count, one count bit a cycle.
// Depends on wmom_pkg for the threshold width and status struct.
module wmom_smul #(
  parameter int WINDOW_MAX = 16,
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1),
  localparam int PROD_W = wmom_pkg::THR_W + CNT_W + 1,
  localparam int STEP_W = $clog2(CNT_W + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [wmom_pkg::THR_W-1:0] thr,
  input  logic [CNT_W-1:0]                  count,
  output logic signed [PROD_W-1:0]          product,
  output wmom_pkg::seq_stat_t               stat
);

  logic signed [PROD_W-1:0] mcand;
  logic [CNT_W-1:0]         mplier;
  logic [STEP_W-1:0]        steps;

  // Add the shifted threshold for each set count bit
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '{busy: 1'b0, done: 1'b0};
      steps <= '0;
    end else if (start) begin
      product <= '0;
      mcand   <= PROD_W'(thr);
      mplier  <= count;
      steps   <= STEP_W'(CNT_W);
      stat    <= '{busy: 1'b1, done: 1'b0};
    end else if (stat.busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      steps  <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        stat <= '{busy: 1'b0, done: 1'b1};
      end
    end
  end

endmodule

[sv/wmom_sdiv.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: signed running sum over fill count, toward zero.
// Depends on wmom_pkg for the status struct.
module wmom_sdiv #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16,
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1),
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1,
  localparam int STEP_W = $clog2(SUM_W + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SUM_W-1:0]       dividend,
  input  logic [CNT_W-1:0]              divisor,
  output logic signed [SAMPLE_BITS-1:0] quotient,
  output wmom_pkg::seq_stat_t           stat
);

  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  dvd;
  logic [SUM_W-1:0]  q_signed;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor_q;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic              neg;
  logic [STEP_W-1:0] steps;

  // Divide magnitudes, restore the sign at the end
  assign mag   = dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
  assign trial = {rem, dvd[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor_q});

  // One quotient bit per cycle; quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '{busy: 1'b0, done: 1'b0};
      steps <= '0;
    end else if (start) begin
      dvd       <= mag;
      neg       <= dividend[SUM_W-1];
      divisor_q <= divisor;
      rem       <= '0;
      steps     <= STEP_W'(SUM_W);
      stat      <= '{busy: 1'b1, done: 1'b0};
    end else if (stat.busy) begin
      rem   <= fits ? CNT_W'(trial - {1'b0, divisor_q}) : CNT_W'(trial);
      dvd   <= {dvd[SUM_W-2:0], fits};
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        stat <= '{busy: 1'b0, done: 1'b1};
      end
    end
  end

  assign q_signed = neg ? (~dvd + 1'b1) : dvd;
  assign quotient = $signed(q_signed[SAMPLE_BITS-1:0]);

endmodule

[sv/windowed_mean_overheat_monitor_unit.sv]
`timescale 1ns / 1ps
// Top level of the windowed mean overheat monitor: sequencer, registers, result beat.
// Depends on wmom_pkg, the channel interfaces, wmom_window, wmom_smul and wmom_sdiv.
//
// Boxcar moving average of stamped Q8.8 temperature samples. A sample beat whose
// seconds and nanoseconds are both zero is taken while idle and dropped with no
// result. Every other sample enters a window of the newest window_length samples
// (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX) and produces one result
// beat: the window mean truncated toward zero and an overheat flag that is set
// when sum > overheat_threshold * fill_count. One stamped sample occupies the
// block for a memory read, the window update, and a bit-serial divider that
// resolves one quotient bit per cycle; the threshold product is formed alongside
// it. The result sits in an output register; the block takes a new sample once
// the divider finishes and the previous result has been taken or is being taken.
// Writing window_length empties the window; write the registers only while the
// block is idle. Sample memory needs no clearing pass.
module windowed_mean_overheat_monitor_unit #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input logic             clk,
  input logic             rst,
  wmom_item_if.sink       items,
  wmom_result_if.source   results,
  wmom_cfg_if.sink        cfg
);

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1;
  localparam int PROD_W = wmom_pkg::THR_W + CNT_W + 1;
  localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  wmom_pkg::state_t                state;
  wmom_pkg::state_t                state_next;
  wmom_pkg::win_ctl_t              win_ctl;
  wmom_pkg::seq_stat_t             div_stat;
  wmom_pkg::seq_stat_t             mul_stat;

  logic [wmom_pkg::WLEN_W-1:0]       window_length;
  logic signed [wmom_pkg::THR_W-1:0] threshold;
  logic [CNT_W-1:0]                  len;
  logic                              stamped;
  logic                              arith_start;
  logic                              out_load;
  logic                              out_free;
  logic                              res_valid;
  logic                              over;
  logic signed [SUM_W-1:0]           win_sum;
  logic [CNT_W-1:0]                  win_count;
  logic signed [PROD_W-1:0]          product;
  logic signed [SAMPLE_BITS-1:0]     quotient;
  logic signed [SAMPLE_BITS-1:0]     mean_q;
  logic                              overheat_q;

  // Clamp the window length to the supported range
  always_comb begin
    if (window_length == '0) begin
      len = CNT_W'(1);
    end else if (32'(window_length) > WINDOW_MAX) begin
      len = CNT_W'(WINDOW_MAX);
    end else begin
      len = CNT_W'(window_length);
    end
  end

  assign stamped  = (items.stamp_seconds != '0) || (items.stamp_nanoseconds != '0);
  assign out_free = !res_valid || results.ready;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= wmom_pkg::WLEN_RESET;
      threshold     <= wmom_pkg::THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.idx)
        wmom_pkg::CFG_WINDOW_LENGTH:      window_length <= cfg.data[wmom_pkg::WLEN_W-1:0];
        wmom_pkg::CFG_OVERHEAT_THRESHOLD: threshold <= $signed(cfg.data[wmom_pkg::THR_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmom_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wmom_pkg::ST_IDLE: begin
        if (items.valid && stamped) begin
          state_next = wmom_pkg::ST_READ;
        end
      end
      wmom_pkg::ST_READ:   state_next = wmom_pkg::ST_UPDATE;
      wmom_pkg::ST_UPDATE: state_next = wmom_pkg::ST_START;
      wmom_pkg::ST_START:  state_next = wmom_pkg::ST_DIVIDE;
      wmom_pkg::ST_DIVIDE: begin
        if (div_stat.done && out_free) begin
          state_next = wmom_pkg::ST_IDLE;
        end
      end
      default: state_next = wmom_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    items.ready    = 1'b0;
    win_ctl.clear  = cfg.valid && cfg.ready && (cfg.idx == wmom_pkg::CFG_WINDOW_LENGTH);
    win_ctl.load   = 1'b0;
    win_ctl.commit = 1'b0;
    arith_start    = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      wmom_pkg::ST_IDLE: begin
        items.ready  = 1'b1;
        win_ctl.load = items.valid && stamped;
      end
      wmom_pkg::ST_READ: ;
      wmom_pkg::ST_UPDATE: win_ctl.commit = 1'b1;
      wmom_pkg::ST_START:  arith_start = 1'b1;
      wmom_pkg::ST_DIVIDE: out_load = div_stat.done && out_free;
      default: ;
    endcase
  end

  wmom_window #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .ctl    (win_ctl),
    .len    (len),
    .sample (items.sample),
    .sum    (win_sum),
    .count  (win_count)
  );

  wmom_smul #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_smul (
    .clk     (clk),
    .rst     (rst),
    .start   (arith_start),
    .thr     (threshold),
    .count   (win_count),
    .product (product),
    .stat    (mul_stat)
  );

  wmom_sdiv #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (arith_start),
    .dividend (win_sum),
    .divisor  (win_count),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Exact mean above threshold, compared without division
  assign over = (CMP_W'(win_sum) > CMP_W'(product));

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_q     <= quotient;
      overheat_q <= over;
    end
  end

  assign results.valid    = res_valid;
  assign results.mean     = mean_q;
  assign results.overheat = overheat_q;

  // The threshold product is ready no later than the quotient
  a_mul_before_div: assert property (@(posedge clk) disable iff (rst)
    (state == wmom_pkg::ST_DIVIDE && div_stat.done) |-> mul_stat.done)
    else $error("threshold product not ready when the quotient completed");

  // A divide always sees a nonzero fill count inside the window
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == wmom_pkg::ST_DIVIDE) |-> (win_count != '0 && win_count <= len))
    else $error("fill count out of range during divide");

  // An unstamped sample leaves the sequencer idle
  a_drop_unstamped: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && !stamped) |=> (state == wmom_pkg::ST_IDLE))
    else $error("unstamped sample started a window update");

endmodule

[bench/windowed_mean_overheat_monitor_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the windowed mean overheat monitor: a directed table, then random phases.
// Depends on wmom_pkg, the channel interfaces of wmom_if.sv and the block's RTL.
module windowed_mean_overheat_monitor_unit_tb;

  localparam int WINDOW_MAX    = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 12;
  // Busy time of one stamped sample: read, update, start and the divider, which resolves one quotient bit per cycle
  localparam int BLOCK_CYCLES  = SAMPLE_BITS + $clog2(WINDOW_MAX) + 1 + 5;
  localparam int SETTLE_CYCLES = 2 * BLOCK_CYCLES;
  localparam int NUM_PHASES    = 8;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Short local names for the register indexes
  localparam wmom_pkg::cfg_idx_t REG_WLEN = wmom_pkg::CFG_WINDOW_LENGTH;
  localparam wmom_pkg::cfg_idx_t REG_THR  = wmom_pkg::CFG_OVERHEAT_THRESHOLD;

  // Indexes with no register behind them; writes there must change nothing
  localparam wmom_pkg::cfg_idx_t CFG_SPARE_A = 2'd2;
  localparam wmom_pkg::cfg_idx_t CFG_SPARE_B = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] q88_t;
  localparam q88_t Q88_MAX = 16'sh7FFF;
  localparam q88_t Q88_MIN = 16'sh8000;

  typedef struct packed {
    q88_t mean;
    logic hot;
  } mean_beat_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_PATTERN, SINK_SLOW} sink_mode_t;

  typedef struct packed {
    row_kind_t           kind;
    wmom_pkg::cfg_idx_t  idx;
    logic [15:0]         data;
    q88_t                sample;
    logic [31:0]         sec;
    logic [31:0]         nsec;
    logic [7:0]          reps;
    logic                typed;
    q88_t                mean;
    logic                hot;
  } dir_row_t;

  localparam int N_ROWS = 17;
  // Directed rows; typed results only where they follow directly from the row
  localparam dir_row_t DIRECTED [N_ROWS] = '{
    // first sample after reset at full scale: mean is the sample, above 60 C
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MAX, 32'd1, 32'd0, 8'd1,
      1'b1, Q88_MAX, 1'b1},
    // unstamped sample: dropped, no beat
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MIN, 32'd0, 32'd0, 8'd1,
      1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE, REG_WLEN, 16'h0001, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1,
      1'b1, Q88_MIN, 1'b0},
    // seconds zero, nanoseconds set: still stamped
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MAX, 32'd0, 32'd1, 8'd1,
      1'b1, Q88_MAX, 1'b1},
    '{ROW_WRITE, REG_THR, 16'h7FFF, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    // mean equal to threshold: not above it
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MAX, 32'h8000_0000, 32'd999999999, 8'd1,
      1'b1, Q88_MAX, 1'b0},
    '{ROW_WRITE, REG_THR, 16'h8000, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    // nanoseconds beyond one second are accepted
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MIN, 32'h7FFF_FFFF, 32'd1000000000, 8'd1,
      1'b1, Q88_MIN, 1'b0},
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, 16'sh8001, 32'd1, 32'd0, 8'd1,
      1'b1, 16'sh8001, 1'b1},
    '{ROW_WRITE, CFG_SPARE_A, 16'hFFFF, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    '{ROW_WRITE, CFG_SPARE_B, 16'h0000, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    // window length zero acts as one
    '{ROW_WRITE, REG_WLEN, 16'h0000, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, 16'sh0005, 32'd1, 32'd0, 8'd1,
      1'b1, 16'sh0005, 1'b1},
    // length 31 acts as the maximum; upper data bits are ignored
    '{ROW_WRITE, REG_WLEN, 16'hFFFF, 16'sh0000, 32'd0, 32'd0, 8'd0,
      1'b0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MIN, 32'd1, 32'd0, 8'd16,
      1'b1, Q88_MIN, 1'b0},
    // full window: oldest drops out
    '{ROW_SAMPLE, REG_WLEN, 16'h0000, Q88_MAX, 32'd1, 32'd0, 8'd1,
      1'b0, 16'sh0000, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  wmom_item_if   #(.SAMPLE_BITS(SAMPLE_BITS)) item_ch ();
  wmom_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch ();
  wmom_cfg_if                                 cfg_ch ();

  windowed_mean_overheat_monitor_unit #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (item_ch),
    .results(result_ch),
    .cfg    (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the window and registers
  logic [wmom_pkg::WLEN_W-1:0] wlen_mirror;
  q88_t              thr_mirror;
  q88_t              win_store [WINDOW_MAX];
  int                slot_next;
  int                win_fill;
  longint            win_sum;

  mean_beat_t pending_means [$];

  // Typed result for the beat now offered, driven alongside the item fields
  logic       typed_valid;
  mean_beat_t typed_beat;

  sink_mode_t  sink_mode;
  logic [15:0] sink_pattern;
  int          burst_left;
  int          gap_max;

  int failures;
  int stamped_seen;
  int unstamped_seen;
  int writes_seen;
  int means_checked;
  int hot_seen;
  int unsigned cycle_count;

  // Advance the window by one sample; returns 0 when the sample is unstamped
  function automatic bit predict_window_mean(input q88_t s, input logic [31:0] sec,
                                             input logic [31:0] nsec,
                                             output mean_beat_t beat);
    int len;
    int slot;
    beat = '0;
    if (sec == 32'd0 && nsec == 32'd0) return 1'b0;
    len = (wlen_mirror == '0) ? 1 :
          ((int'(wlen_mirror) > WINDOW_MAX) ? WINDOW_MAX : int'(wlen_mirror));
    slot = (slot_next >= len) ? 0 : slot_next;
    if (win_fill >= len) begin
      win_sum -= win_store[slot];
      win_fill = len;
    end else begin
      win_fill++;
    end
    win_store[slot] = s;
    win_sum += s;
    slot++;
    slot_next = (slot >= len) ? 0 : slot;
    beat.mean = q88_t'(win_sum / win_fill);
    beat.hot  = (win_sum > longint'(thr_mirror) * win_fill);
    return 1'b1;
  endfunction

  // Watch all three channels: check result beats, predict from sample beats
  always @(posedge clk) begin
    mean_beat_t want;
    if (rst) begin
      wlen_mirror = wmom_pkg::WLEN_RESET;
      thr_mirror  = wmom_pkg::THR_RESET;
      slot_next   = 0;
      win_fill    = 0;
      win_sum     = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_means.size() == 0) begin
          $error("result beat with nothing expected: mean %0d, overheat %0b",
                 result_ch.mean, result_ch.overheat);
          failures++;
        end else begin
          want = pending_means[0];
          pending_means.delete(0);
          means_checked++;
          if (result_ch.overheat) hot_seen++;
          if (result_ch.mean !== want.mean) begin
            $error("mean: expected %0d, got %0d", want.mean, result_ch.mean);
            failures++;
          end
          if (result_ch.overheat !== want.hot) begin
            $error("overheat: expected %0b, got %0b", want.hot, result_ch.overheat);
            failures++;
          end
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        if (predict_window_mean(item_ch.sample, item_ch.stamp_seconds,
                                item_ch.stamp_nanoseconds, want)) begin
          if (typed_valid) want = typed_beat;
          pending_means = {pending_means, want};
          stamped_seen++;
        end else begin
          unstamped_seen++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        writes_seen++;
        case (cfg_ch.idx)
          wmom_pkg::CFG_WINDOW_LENGTH: begin
            wlen_mirror = cfg_ch.data[wmom_pkg::WLEN_W-1:0];
            slot_next   = 0;
            win_fill    = 0;
            win_sum     = 0;
          end
          wmom_pkg::CFG_OVERHEAT_THRESHOLD: begin
            thr_mirror = q88_t'(cfg_ch.data);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result side: stall per the current mode
  initial begin : result_sink
    logic [3:0] tick;
    tick = '0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick = tick + 1'b1;
      case (sink_mode)
        SINK_OPEN:    result_ch.ready <= 1'b1;
        SINK_PATTERN: result_ch.ready <= sink_pattern[tick];
        default:      result_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Give up after a generous number of cycles
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** windowed_mean_overheat_monitor_unit: FAILED **");
    $finish;
  end

  // End a burst at random and hold valid low for a random gap
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        gap = $urandom_range(1, gap_max);
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Offer one sample beat and wait for it to be taken
  task automatic put_sample(input q88_t s, input logic [31:0] sec, input logic [31:0] nsec,
                            input logic typed, input mean_beat_t tbeat);
    item_ch.valid             <= 1'b1;
    item_ch.sample            <= s;
    item_ch.stamp_seconds     <= sec;
    item_ch.stamp_nanoseconds <= nsec;
    typed_valid               <= typed;
    typed_beat                <= tbeat;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pace_sender();
  endtask

  task automatic write_reg(input wmom_pkg::cfg_idx_t idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, drain all expected beats, then let the block settle
  task automatic quiesce();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          stamped;
    int          level;
    int          spread;
    int          v;
    int          pick;
    logic [31:0] sec;
    logic [31:0] nsec;
    q88_t        s;
    logic [15:0] thr_data;

    // Known values on every input from time zero
    rst                       <= 1'b1;
    item_ch.valid             <= 1'b0;
    item_ch.sample            <= '0;
    item_ch.stamp_seconds     <= '0;
    item_ch.stamp_nanoseconds <= '0;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.idx                <= REG_WLEN;
    cfg_ch.data               <= '0;
    typed_valid               <= 1'b0;
    typed_beat                <= '0;
    sink_mode                 <= SINK_PATTERN;
    sink_pattern              <= 16'hB5AD;
    failures       = 0;
    stamped_seen   = 0;
    unstamped_seen = 0;
    writes_seen    = 0;
    means_checked  = 0;
    hot_seen       = 0;
    burst_left     = 1;
    gap_max        = 3;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        quiesce();
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        for (int k = 0; k < int'(DIRECTED[r].reps); k++) begin
          put_sample(DIRECTED[r].sample, DIRECTED[r].sec, DIRECTED[r].nsec,
                     DIRECTED[r].typed, '{DIRECTED[r].mean, DIRECTED[r].hot});
        end
      end
    end

    // Random phases, each with its own threshold, pacing and sample level
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      sink_mode    <= sink_mode_t'(p % 3);
      sink_pattern <= 16'($urandom()) | 16'h0101;
      case ((p / 2) % 3)
        0:       gap_max = 0;
        1:       gap_max = 4;
        default: gap_max = 30;
      endcase
      level  = int'($urandom_range(0, 60000)) - 30000;
      spread = int'($urandom_range(16, 2048));

      // Window length: extremes first, kept across some phases
      case (p)
        0: write_reg(REG_WLEN, {11'($urandom()), 5'd1});
        1: write_reg(REG_WLEN, {11'($urandom()), 5'd16});
        2: write_reg(REG_WLEN, {11'($urandom()), 5'd31});
        3: write_reg(REG_WLEN, {11'($urandom()), 5'd0});
        4: write_reg(REG_WLEN, {11'($urandom()), 5'd17});
        6: write_reg(REG_WLEN, {11'($urandom()), 5'($urandom_range(2, 15))});
        default: begin
        end
      endcase

      // Threshold: extremes, full random, or close to the sample level
      case (p)
        1: thr_data = 16'h8000;
        2: thr_data = 16'h7FFF;
        6: thr_data = 16'($urandom());
        default: begin
          v = level + int'($urandom_range(0, 512)) - 256;
          thr_data = 16'(v);
        end
      endcase
      write_reg(REG_THR, thr_data);
      if (p == 6) write_reg(CFG_SPARE_A, 16'($urandom()));
      if (p == 7) write_reg(CFG_SPARE_B, 16'($urandom()));

      stamped = 0;
      while (stamped < RANDOM_ITEMS / NUM_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          s = $urandom_range(0, 1) ? Q88_MAX : Q88_MIN;
        end else if (pick < 25) begin
          s = q88_t'($urandom());
        end else begin
          v = level + int'($urandom_range(0, 2 * spread)) - spread;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          s = q88_t'(v);
        end
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          sec  = 32'd0;
          nsec = 32'd0;
        end else if (pick < 14) begin
          sec  = 32'd0;
          nsec = $urandom();
          if (nsec == 32'd0) nsec = 32'd1;
        end else if (pick < 22) begin
          sec  = $urandom();
          if (sec == 32'd0) sec = 32'd1;
          nsec = 32'd0;
        end else begin
          sec  = $urandom();
          nsec = $urandom();
        end
        if (sec != 32'd0 || nsec != 32'd0) stamped++;
        put_sample(s, sec, nsec, 1'b0, '0);
      end
    end

    quiesce();
    if (pending_means.size() != 0) begin
      $error("%0d expected mean beats never arrived", pending_means.size());
    end
    $display("Run covered %0d stamped and %0d unstamped samples, %0d register writes, %0d phases.",
             stamped_seen, unstamped_seen, writes_seen, NUM_PHASES);
    $display("Checked %0d mean beats, %0d with overheat set, in %0d cycles.",
             means_checked, hot_seen, cycle_count);
    if (failures == 0 && pending_means.size() == 0) begin
      $display("** windowed_mean_overheat_monitor_unit: PASSED **");
    end else begin
      $display("** windowed_mean_overheat_monitor_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
sv/wmom_pkg.sv
sv/wmom_if.sv
sv/wmom_window.sv
sv/wmom_smul.sv
sv/wmom_sdiv.sv
sv/windowed_mean_overheat_monitor_unit.sv
bench/windowed_mean_overheat_monitor_unit_tb.sv
